FILE: hw/rtl/sha1_pkg.sv
package sha1_pkg;

    // Input item kinds.
    localparam logic KIND_DATA   = 1'b0;
    localparam logic KIND_FINISH = 1'b1;

    // Block and padding geometry.
    localparam int BLOCK_BYTES  = 64;
    localparam int LEN_POS      = 56;
    localparam int ROUNDS       = 80;
    localparam int DIGEST_WORDS = 5;
    localparam int ROUND_W      = 7;
    localparam int FILL_W       = 6;
    localparam int TOTAL_W      = 61;
    localparam int INDEX_W      = 3;

    localparam logic [7:0] PAD_MARK = 8'h80;

    localparam logic [31:0] H_INIT [0:DIGEST_WORDS-1] = '{
        32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
    };

    localparam logic [31:0] K_PHASE0 = 32'h5A827999;
    localparam logic [31:0] K_PHASE1 = 32'h6ED9EBA1;
    localparam logic [31:0] K_PHASE2 = 32'h8F1BBCDC;
    localparam logic [31:0] K_PHASE3 = 32'hCA62C1D6;

    typedef struct packed {
        logic       kind;
        logic [7:0] data_byte;
    } msg_item_t;

    typedef struct packed {
        logic [31:0]        digest_word;
        logic [INDEX_W-1:0] word_index;
        logic               last_word;
    } dig_item_t;

    function automatic logic [31:0] rotl(input logic [31:0] x, input int n);
        rotl = (x << n) | (x >> (32 - n));
    endfunction

    // Round function, chosen by which group of twenty rounds is running.
    function automatic logic [31:0] sha1_f(input logic [ROUND_W-1:0] rnd,
                                           input logic [31:0] b,
                                           input logic [31:0] c,
                                           input logic [31:0] d);
        if (rnd < ROUND_W'(20)) begin
            sha1_f = (b & c) | (~b & d);
        end else if (rnd < ROUND_W'(40)) begin
            sha1_f = b ^ c ^ d;
        end else if (rnd < ROUND_W'(60)) begin
            sha1_f = (b & c) | (b & d) | (c & d);
        end else begin
            sha1_f = b ^ c ^ d;
        end
    endfunction

    function automatic logic [31:0] sha1_k(input logic [ROUND_W-1:0] rnd);
        if (rnd < ROUND_W'(20)) begin
            sha1_k = K_PHASE0;
        end else if (rnd < ROUND_W'(40)) begin
            sha1_k = K_PHASE1;
        end else if (rnd < ROUND_W'(60)) begin
            sha1_k = K_PHASE2;
        end else begin
            sha1_k = K_PHASE3;
        end
    endfunction

endpackage

FILE: hw/rtl/sha1_stream_hasher.sv
// SHA-1 hasher over a byte stream.
// The msg channel carries items of two kinds: a data item appends one message
// byte, and a finish item closes the message. A data item that does not
// complete a 64-byte block is taken with no stall. The item that completes a
// block starts the compression, which runs one round per cycle through a
// single shared round unit: 80 rounds, then a step that folds the result into
// the chaining words; msg_stall stays high until that fold is done.
// A finish item streams the padding through the same byte path (one byte a
// cycle outside compressions, up to 64 bytes before the length field, then
// 8 length bytes) and runs one or two compressions. The five digest words leave
// on the dig channel, h0 first, one per cycle while the receiver does not stall;
// after the fifth is taken the block is back in its initial state. msg_stall is
// high whenever the block is busy with anything but waiting for the next item.
// A stall on dig simply holds the current word; nothing is lost.
// Reset (rst_n low, asynchronous) loads the initial chaining words, clears the
// byte counts and returns the sequencer to idle. The message bytes themselves
// live in the 16-word schedule window, which needs no reset.
module sha1_stream_hasher (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                msg_valid,
    output logic                msg_stall,
    input  sha1_pkg::msg_item_t msg,
    output logic                dig_valid,
    input  logic                dig_stall,
    output sha1_pkg::dig_item_t dig
);
    import sha1_pkg::*;

    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_PAD_ONE  = 3'd1;
    localparam logic [2:0] ST_PAD_ZERO = 3'd2;
    localparam logic [2:0] ST_PAD_LEN  = 3'd3;
    localparam logic [2:0] ST_ROUND    = 3'd4;
    localparam logic [2:0] ST_ADD      = 3'd5;
    localparam logic [2:0] ST_OUT      = 3'd6;

    logic [2:0]         state_reg, state_next;
    logic [2:0]         ret_reg, ret_next;
    logic [FILL_W-1:0]  fill_reg, fill_next;
    logic [TOTAL_W-1:0] total_reg, total_next;
    logic [ROUND_W-1:0] rnd_reg, rnd_next;
    logic [INDEX_W-1:0] idx_reg, idx_next;
    logic [31:0]        h_reg [0:DIGEST_WORDS-1];
    logic [31:0]        h_next [0:DIGEST_WORDS-1];
    logic [31:0]        work_reg [0:DIGEST_WORDS-1];
    logic [31:0]        work_next [0:DIGEST_WORDS-1];
    logic [31:0]        win_reg [0:15];
    logic [31:0]        win_next [0:15];

    logic               push;
    logic [7:0]         push_byte;
    logic [31:0]        round_t;
    logic [31:0]        round_w;

    sha1_round u_round (
        .rnd   (rnd_reg),
        .a     (work_reg[0]),
        .b     (work_reg[1]),
        .c     (work_reg[2]),
        .d     (work_reg[3]),
        .e     (work_reg[4]),
        .w0    (win_reg[0]),
        .w2    (win_reg[2]),
        .w8    (win_reg[8]),
        .w13   (win_reg[13]),
        .t     (round_t),
        .w_new (round_w)
    );

    assign msg_stall        = (state_reg != ST_IDLE);
    assign dig_valid        = (state_reg == ST_OUT);
    assign dig.digest_word  = h_reg[0];
    assign dig.word_index   = idx_reg;
    assign dig.last_word    = (idx_reg == INDEX_W'(DIGEST_WORDS - 1));

    always_comb
    begin
        state_next = state_reg;
        ret_next   = ret_reg;
        fill_next  = fill_reg;
        total_next = total_reg;
        rnd_next   = rnd_reg;
        idx_next   = idx_reg;
        h_next     = h_reg;
        work_next  = work_reg;
        win_next   = win_reg;
        push       = 1'b0;
        push_byte  = 8'h00;

        case (state_reg)
            ST_IDLE:
            begin
                if (msg_valid)
                begin
                    if (msg.kind == KIND_FINISH)
                    begin
                        state_next = ST_PAD_ONE;
                    end
                    else
                    begin
                        push       = 1'b1;
                        push_byte  = msg.data_byte;
                        total_next = total_reg + TOTAL_W'(1);
                    end
                end
            end
            ST_PAD_ONE:
            begin
                push       = 1'b1;
                push_byte  = PAD_MARK;
                state_next = ST_PAD_ZERO;
            end
            ST_PAD_ZERO:
            begin
                // Zeros run on, through a block boundary if need be, until
                // the length field is reached.
                if (fill_reg == FILL_W'(LEN_POS))
                begin
                    state_next = ST_PAD_LEN;
                end
                else
                begin
                    push = 1'b1;
                end
            end
            ST_PAD_LEN:
            begin
                // Bit length, most significant byte first: the byte count
                // shifted left by three.
                push       = 1'b1;
                push_byte  = total_reg[TOTAL_W-1 -: 8];
                total_next = {total_reg[TOTAL_W-9:0], 8'h00};
                if (fill_reg == FILL_W'(BLOCK_BYTES - 1))
                begin
                    state_next = ST_OUT;
                end
            end
            ST_ROUND:
            begin
                work_next[0] = round_t;
                work_next[1] = work_reg[0];
                work_next[2] = rotl(work_reg[1], 30);
                work_next[3] = work_reg[2];
                work_next[4] = work_reg[3];
                for (int i = 0; i < 15; i++)
                begin
                    win_next[i] = win_reg[i + 1];
                end
                win_next[15] = round_w;
                rnd_next     = rnd_reg + ROUND_W'(1);
                if (rnd_reg == ROUND_W'(ROUNDS - 1))
                begin
                    state_next = ST_ADD;
                end
            end
            ST_ADD:
            begin
                for (int i = 0; i < DIGEST_WORDS; i++)
                begin
                    h_next[i] = h_reg[i] + work_reg[i];
                end
                state_next = ret_reg;
            end
            ST_OUT:
            begin
                if (!dig_stall)
                begin
                    for (int i = 0; i < DIGEST_WORDS - 1; i++)
                    begin
                        h_next[i] = h_reg[i + 1];
                    end
                    h_next[DIGEST_WORDS-1] = h_reg[0];
                    idx_next = idx_reg + INDEX_W'(1);
                    if (idx_reg == INDEX_W'(DIGEST_WORDS - 1))
                    begin
                        h_next     = H_INIT;
                        idx_next   = '0;
                        fill_next  = '0;
                        total_next = '0;
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // Every byte, message or padding, shifts into the window as one
        // 512-bit line. The byte that fills it starts the compression, which
        // returns to wherever the byte stream was heading.
        if (push)
        begin
            for (int i = 0; i < 15; i++)
            begin
                win_next[i] = {win_reg[i][23:0], win_reg[i + 1][31:24]};
            end
            win_next[15] = {win_reg[15][23:0], push_byte};
            fill_next    = fill_reg + FILL_W'(1);
            if (fill_reg == FILL_W'(BLOCK_BYTES - 1))
            begin
                ret_next   = state_next;
                state_next = ST_ROUND;
                rnd_next   = '0;
                work_next  = h_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ret_reg   <= ST_IDLE;
            fill_reg  <= '0;
            total_reg <= '0;
            rnd_reg   <= '0;
            idx_reg   <= '0;
            h_reg     <= H_INIT;
        end
        else
        begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
            fill_reg  <= fill_next;
            total_reg <= total_next;
            rnd_reg   <= rnd_next;
            idx_reg   <= idx_next;
            h_reg     <= h_next;
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg <= work_next;
        win_reg  <= win_next;
    end

endmodule

FILE: hw/rtl/sha1_round.sv
module sha1_round (
    input  logic [sha1_pkg::ROUND_W-1:0] rnd,
    input  logic [31:0]                  a,
    input  logic [31:0]                  b,
    input  logic [31:0]                  c,
    input  logic [31:0]                  d,
    input  logic [31:0]                  e,
    input  logic [31:0]                  w0,
    input  logic [31:0]                  w2,
    input  logic [31:0]                  w8,
    input  logic [31:0]                  w13,
    output logic [31:0]                  t,
    output logic [31:0]                  w_new
);
    import sha1_pkg::*;

    // During the rounds the window holds W[r] .. W[r+15], so W[r] is the oldest word.
    assign t     = rotl(a, 5) + sha1_f(rnd, b, c, d) + e + sha1_k(rnd) + w0;
    assign w_new = rotl(w13 ^ w8 ^ w2 ^ w0, 1);

endmodule

FILE: tb/sha1_digest_checker.sv
module sha1_digest_checker
    import sha1_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      msg_valid,
    input  logic      msg_stall,
    input  msg_item_t msg,
    input  logic      dig_valid,
    input  logic      dig_stall,
    input  dig_item_t dig,
    output int        fail_count,
    output int        pending
);

    // Running hash state of the message being taken in.
    logic [31:0]        chain_word [DIGEST_WORDS];
    logic [7:0]         msg_block  [BLOCK_BYTES];
    logic [FILL_W-1:0]  block_fill;
    logic [TOTAL_W-1:0] msg_bytes;
    dig_item_t          digest_due [$];
    int                 mismatches;

    function automatic logic [31:0] rotate_left(input logic [31:0] x, input int n);
        logic [63:0] twice;
        twice = {x, x} << n;
        return twice[63:32];
    endfunction

    function automatic void restart_message();
        for (int i = 0; i < DIGEST_WORDS; i++)
        begin
            chain_word[i] = H_INIT[i];
        end
        block_fill = '0;
        msg_bytes  = '0;
    endfunction

    function automatic void compress_msg_block();
        logic [31:0] w [16];
        logic [31:0] a, b, c, d, e, f, k, t;
        for (int i = 0; i < 16; i++)
        begin
            w[i] = {msg_block[4*i], msg_block[4*i+1], msg_block[4*i+2], msg_block[4*i+3]};
        end
        a = chain_word[0];
        b = chain_word[1];
        c = chain_word[2];
        d = chain_word[3];
        e = chain_word[4];
        for (int r = 0; r < ROUNDS; r++)
        begin
            if (r >= 16)
            begin
                w[r % 16] = rotate_left(w[(r + 13) % 16] ^ w[(r + 8) % 16] ^
                                        w[(r + 2) % 16] ^ w[r % 16], 1);
            end
            if (r < 20)
            begin
                f = (b & c) | (~b & d);
                k = K_PHASE0;
            end
            else if (r < 40)
            begin
                f = b ^ c ^ d;
                k = K_PHASE1;
            end
            else if (r < 60)
            begin
                f = (b & c) | (b & d) | (c & d);
                k = K_PHASE2;
            end
            else
            begin
                f = b ^ c ^ d;
                k = K_PHASE3;
            end
            t = rotate_left(a, 5) + f + e + k + w[r % 16];
            e = d;
            d = c;
            c = rotate_left(b, 30);
            b = a;
            a = t;
        end
        chain_word[0] += a;
        chain_word[1] += b;
        chain_word[2] += c;
        chain_word[3] += d;
        chain_word[4] += e;
    endfunction

    // Pads the message, runs the last one or two blocks and queues the digest.
    function automatic void close_message();
        logic [63:0] bit_len;
        int          pos;
        dig_item_t   word;
        bit_len = {msg_bytes, 3'b000};
        pos = int'(block_fill);
        msg_block[pos] = PAD_MARK;
        pos++;
        if (pos > LEN_POS)
        begin
            while (pos < BLOCK_BYTES)
            begin
                msg_block[pos] = 8'h00;
                pos++;
            end
            compress_msg_block();
            pos = 0;
        end
        while (pos < LEN_POS)
        begin
            msg_block[pos] = 8'h00;
            pos++;
        end
        for (int i = 0; i < 8; i++)
        begin
            msg_block[LEN_POS + i] = bit_len[63 - 8*i -: 8];
        end
        compress_msg_block();
        for (int i = 0; i < DIGEST_WORDS; i++)
        begin
            word.digest_word = chain_word[i];
            word.word_index  = INDEX_W'(i);
            word.last_word   = (i == DIGEST_WORDS - 1);
            digest_due.push_back(word);
        end
        restart_message();
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        dig_item_t want;
        if (!rst_n)
        begin
            restart_message();
            digest_due.delete();
            mismatches = 0;
        end
        else
        begin
            if (dig_valid && !dig_stall)
            begin
                if (digest_due.size() == 0)
                begin
                    $error("digest word %h arrived with none outstanding", dig.digest_word);
                    mismatches++;
                end
                else
                begin
                    want = digest_due.pop_front();
                    if (dig.digest_word !== want.digest_word)
                    begin
                        $error("digest_word: expected %h, got %h",
                               want.digest_word, dig.digest_word);
                        mismatches++;
                    end
                    if (dig.word_index !== want.word_index)
                    begin
                        $error("word_index: expected %0d, got %0d",
                               want.word_index, dig.word_index);
                        mismatches++;
                    end
                    if (dig.last_word !== want.last_word)
                    begin
                        $error("last_word: expected %b, got %b",
                               want.last_word, dig.last_word);
                        mismatches++;
                    end
                end
            end
            if (msg_valid && !msg_stall)
            begin
                if (msg.kind == KIND_DATA)
                begin
                    msg_block[block_fill] = msg.data_byte;
                    block_fill = block_fill + FILL_W'(1);
                    msg_bytes  = msg_bytes + TOTAL_W'(1);
                    if (block_fill == '0)
                    begin
                        compress_msg_block();
                    end
                end
                else
                begin
                    close_message();
                end
            end
        end
        fail_count <= mismatches;
        pending    <= digest_due.size();
    end

endmodule

FILE: tb/tb_sha1_stream_hasher.sv
// Testbench top for the streaming SHA-1 hasher. This module only makes
// stimulus and gives the verdict; the checker beside the block watches both
// channels, predicts every digest and compares it word by word.
module tb_sha1_stream_hasher;

    import sha1_pkg::*;

    // Length of the one long hold-off on the digest side, in cycles.
    localparam int HOLD_CYCLES  = 250;
    // Cycles with no item accepted on either channel before the run is abandoned.
    // The slowest correct gaps are the long hold-off and a two-block finish,
    // so this leaves ample margin.
    localparam int QUIET_LIMIT  = 4000;
    // Number of messages in the random part.
    localparam int RANDOM_MESSAGES = 12;
    // Cycles allowed after the last digest word for anything stray to show up.
    localparam int TAIL_CYCLES  = 200;

    logic      clk;
    logic      rst_n;
    logic      msg_valid;
    logic      msg_stall;
    msg_item_t msg;
    logic      dig_valid;
    logic      dig_stall;
    dig_item_t dig;

    int   fail_count;
    int   pending;
    // When set, neither side idles, giving a stretch at full rate.
    logic calm = 1'b0;
    // Each increment asks the receiver for one long hold-off.
    int   hold_asks = 0;
    int   quiet_cycles = 0;

    sha1_stream_hasher uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .msg_valid (msg_valid),
        .msg_stall (msg_stall),
        .msg       (msg),
        .dig_valid (dig_valid),
        .dig_stall (dig_stall),
        .dig       (dig)
    );

    sha1_digest_checker digest_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .msg_valid  (msg_valid),
        .msg_stall  (msg_stall),
        .msg        (msg),
        .dig_valid  (dig_valid),
        .dig_stall  (dig_stall),
        .dig        (dig),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Watchdog: a hung block shows up as a long run of cycles in which no
    // item moves on either channel.
    always @(posedge clk)
    begin
        if (!rst_n || (msg_valid && !msg_stall) || (dig_valid && !dig_stall))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Receiver. It normally stalls at random, but when a hold-off is asked for
    // it keeps stall high for a long count of its own, so that the digest
    // words back up and the block has to refuse further message items.
    initial
    begin : receiver
        int served;
        served    = 0;
        dig_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (served != hold_asks)
            begin
                served++;
                dig_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
                dig_stall <= 1'b0;
            end
            else
            begin
                dig_stall <= !calm && ($urandom_range(0, 99) < 22);
            end
        end
    end

    // Offers one item, idling at random first, and returns at the falling edge
    // after the item has been accepted. Valid stays high from one item to the
    // next unless an idle cycle falls between them.
    task automatic send_item(input logic kind, input logic [7:0] data_byte);
        while (!calm && ($urandom_range(0, 99) < 22))
        begin
            msg_valid <= 1'b0;
            @(negedge clk);
        end
        msg_valid <= 1'b1;
        msg.kind      <= kind;
        msg.data_byte <= data_byte;
        do
        begin
            @(posedge clk);
        end
        while (msg_stall);
        @(negedge clk);
    endtask

    // A whole message of random bytes, closed by a finish whose byte is
    // random too, since the block must ignore it.
    task automatic send_message(input int len);
        for (int i = 0; i < len; i++)
        begin
            send_item(KIND_DATA, 8'($urandom_range(0, 255)));
        end
        send_item(KIND_FINISH, 8'($urandom_range(0, 255)));
    endtask

    // Holds the sender back until every predicted digest word has come out.
    task automatic drain_digests();
        msg_valid <= 1'b0;
        while (pending != 0)
        begin
            @(posedge clk);
        end
        @(negedge clk);
    endtask

    initial
    begin : stimulus
        int msg_count;
        int len;

        rst_n     = 1'b0;
        msg_valid = 1'b0;
        msg       = '0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed part. The empty message comes first, straight after reset,
        // then again with every bit of the ignored finish byte set.
        send_item(KIND_FINISH, 8'h00);
        send_item(KIND_FINISH, 8'hFF);
        // The classic three-byte message "abc".
        send_item(KIND_DATA, 8'h61);
        send_item(KIND_DATA, 8'h62);
        send_item(KIND_DATA, 8'h63);
        send_item(KIND_FINISH, 8'h00);
        // Extreme and alternating byte values, closed by a finish byte of 8'h5A.
        send_item(KIND_DATA, 8'h00);
        send_item(KIND_DATA, 8'hFF);
        send_item(KIND_DATA, 8'h55);
        send_item(KIND_DATA, 8'hAA);
        send_item(KIND_FINISH, 8'h5A);
        // A single byte, finished at once.
        send_item(KIND_DATA, 8'h80);
        send_item(KIND_FINISH, 8'hA5);
        drain_digests();

        // Random part. The first message is long enough that the padding spills
        // into a second block; the second is exactly one full block of data.
        // After that the messages are short.
        msg_count = 0;
        while (msg_count < RANDOM_MESSAGES)
        begin
            if (msg_count == 0)
            begin
                len = $urandom_range(LEN_POS, LEN_POS + 2);
            end
            else if (msg_count == 1)
            begin
                len = BLOCK_BYTES;
            end
            else
            begin
                len = $urandom_range(0, 3);
            end

            // Ask the receiver for its long hold-off while the sender keeps going.
            if (msg_count == 4)
            begin
                hold_asks <= hold_asks + 1;
            end
            // Pause the sender until the block has emptied.
            if (msg_count == 7)
            begin
                drain_digests();
            end
            // A stretch at full rate on both sides.
            if (msg_count == 8)
            begin
                calm <= 1'b1;
            end
            if (msg_count == 11)
            begin
                calm <= 1'b0;
            end

            send_message(len);
            msg_count++;
        end

        drain_digests();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

FILE: sha1_stream_hasher.f
hw/rtl/sha1_pkg.sv
hw/rtl/sha1_round.sv
hw/rtl/sha1_stream_hasher.sv
tb/sha1_digest_checker.sv
tb/tb_sha1_stream_hasher.sv
